/* rtl/core/bmp_row_to_packed_pixel_converter_defines.svh */
// Assertion macros shared by the converter RTL.
`ifndef BMP_ROW_TO_PACKED_PIXEL_CONVERTER_DEFINES_SVH
`define BMP_ROW_TO_PACKED_PIXEL_CONVERTER_DEFINES_SVH

// Checks that a condition holds at every clock edge outside reset.
`define BMP_ASSERT_ALWAYS(label, clk, rstn, expr, msg) \
  label: assert property (@(posedge clk) disable iff (!(rstn)) (expr)) \
    else $error(msg);

// Checks that a condition in one cycle brings a consequence in the next cycle.
`define BMP_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* rtl/core/bmp_pkg.sv */
// Types and constants shared by the BMP packed-pixel converter modules.
`default_nettype none

package bmp_pkg;

  // Output formats selected by the mode register.
  typedef enum logic [1:0] {
    MODE_RGB332 = 2'd0,
    MODE_PAIR12 = 2'd1,
    MODE_RGB565 = 2'd2,
    MODE_RGB888 = 2'd3
  } mode_e;

  // Configuration register indexes.
  localparam logic [1:0] REG_WIDTH  = 2'd0;
  localparam logic [1:0] REG_HEIGHT = 2'd1;
  localparam logic [1:0] REG_MODE   = 2'd2;

  localparam int unsigned DIM_W       = 13;
  localparam int unsigned MAX_RESULTS = 3;

  // Result queue geometry.
  localparam int unsigned QDEPTH = 4;
  localparam int unsigned QPW    = $clog2(QDEPTH);
  localparam int unsigned QCW    = $clog2(QDEPTH + 1);

  // Color byte positions within a pixel.
  localparam logic [1:0] COMP_BLUE  = 2'd0;
  localparam logic [1:0] COMP_GREEN = 2'd1;
  localparam logic [1:0] COMP_RED   = 2'd2;

  // One output byte with its flags.
  typedef struct packed {
    logic [7:0] out_byte;
    logic       last_of_run;
    logic       image_end;
  } res_entry_t;

  // Results caused by one input item.
  typedef struct packed {
    logic [1:0]            count;
    res_entry_t [MAX_RESULTS-1:0] entry;
  } res_group_t;

endpackage

`default_nettype wire

/* rtl/core/bmp_pixel_asm.sv */
// Pixel assembler: drops row padding, collects BGR bytes and formats each pixel.
`default_nettype none

module bmp_pixel_asm import bmp_pkg::*; #(
  parameter int unsigned MAX_WIDTH  = 4096,
  parameter int unsigned MAX_HEIGHT = 4096
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             clear_i,
  input  wire logic             accept_i,
  input  wire logic [7:0]       data_byte_i,
  input  wire logic [DIM_W-1:0] width_i,
  input  wire logic [DIM_W-1:0] height_i,
  input  wire mode_e            mode_i,
  output logic                  will_emit_o,
  output res_group_t            result_o
);

  localparam int unsigned CW = $clog2(MAX_WIDTH);
  localparam int unsigned RW = $clog2(MAX_HEIGHT);

  logic [1:0]    comp_q, comp_d;
  logic [7:0]    blue_q, blue_d;
  logic [7:0]    green_q, green_d;
  logic [CW-1:0] col_q, col_d;
  logic [RW-1:0] row_q, row_d;
  logic [1:0]    pad_q, pad_d;
  logic          pair_q, pair_d;
  logic [11:0]   pend_q, pend_d;

  logic [7:0] r, g, b;
  logic       last_col, last_row, last_pix;
  logic [7:0] b0, b1, b2;
  logic [1:0] n;

  // A pixel completes only on its red byte outside the padding.
  assign will_emit_o = (pad_q == 2'd0) && (comp_q == COMP_RED);

  assign r = data_byte_i;
  assign g = green_q;
  assign b = blue_q;

  assign last_col = (32'(col_q) + 32'd1) == 32'(width_i);
  assign last_row = (32'(row_q) + 32'd1) == 32'(height_i);
  assign last_pix = last_col && last_row;

  // Format the completed pixel and update the stream position.
  always_comb begin
    comp_d  = comp_q;
    blue_d  = blue_q;
    green_d = green_q;
    col_d   = col_q;
    row_d   = row_q;
    pad_d   = pad_q;
    pair_d  = pair_q;
    pend_d  = pend_q;
    b0      = r;
    b1      = g;
    b2      = b;
    n       = 2'd0;

    if (pad_q != 2'd0) begin
      pad_d = pad_q - 2'd1;
    end else if (comp_q == COMP_BLUE) begin
      blue_d = data_byte_i;
      comp_d = COMP_GREEN;
    end else if (comp_q == COMP_GREEN) begin
      green_d = data_byte_i;
      comp_d  = COMP_RED;
    end else begin
      comp_d = COMP_BLUE;
      unique case (mode_i)
        MODE_RGB332: begin
          b0 = {r[7:5], g[7:5], b[7:6]};
          n  = 2'd1;
        end
        MODE_PAIR12: begin
          if (pair_q) begin
            b0     = pend_q[11:4];
            b1     = {pend_q[3:0], r[7:4]};
            b2     = {g[7:4], b[7:4]};
            n      = 2'd3;
            pair_d = 1'b0;
            pend_d = 12'h000;
          end else if (last_pix) begin
            b0 = {r[7:4], g[7:4]};
            b1 = {b[7:4], 4'h0};
            n  = 2'd2;
          end else begin
            pend_d = {r[7:4], g[7:4], b[7:4]};
            pair_d = 1'b1;
          end
        end
        MODE_RGB565: begin
          b0 = {r[7:3], g[7:5]};
          b1 = {g[4:2], b[7:3]};
          n  = 2'd2;
        end
        MODE_RGB888: begin
          n = 2'd3;
        end
        default: begin
          n = 2'd0;
        end
      endcase

      // Row padding brings each row to a multiple of four bytes.
      if (last_col) begin
        col_d = '0;
        pad_d = width_i[1:0];
        if (last_row) begin
          row_d  = '0;
          pair_d = 1'b0;
          pend_d = 12'h000;
        end else begin
          row_d = row_q + RW'(1);
        end
      end else begin
        col_d = col_q + CW'(1);
      end
    end
  end

  // Result bytes with run and image flags on the last one.
  always_comb begin
    result_o.count             = n;
    result_o.entry[0].out_byte = b0;
    result_o.entry[1].out_byte = b1;
    result_o.entry[2].out_byte = b2;
    for (int k = 0; k < int'(MAX_RESULTS); k++) begin
      result_o.entry[k].last_of_run = (32'(n) == 32'(k + 1));
      result_o.entry[k].image_end   = (32'(n) == 32'(k + 1)) && last_pix;
    end
  end

  // Stream state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      comp_q  <= COMP_BLUE;
      blue_q  <= 8'h00;
      green_q <= 8'h00;
      col_q   <= '0;
      row_q   <= '0;
      pad_q   <= 2'd0;
      pair_q  <= 1'b0;
      pend_q  <= 12'h000;
    end else if (clear_i) begin
      comp_q  <= COMP_BLUE;
      blue_q  <= 8'h00;
      green_q <= 8'h00;
      col_q   <= '0;
      row_q   <= '0;
      pad_q   <= 2'd0;
      pair_q  <= 1'b0;
      pend_q  <= 12'h000;
    end else if (accept_i) begin
      comp_q  <= comp_d;
      blue_q  <= blue_d;
      green_q <= green_d;
      col_q   <= col_d;
      row_q   <= row_d;
      pad_q   <= pad_d;
      pair_q  <= pair_d;
      pend_q  <= pend_d;
    end
  end

endmodule

`default_nettype wire

/* rtl/core/bmp_out_queue.sv */
// Result queue: takes up to three bytes per cycle and hands out one per cycle while the output is not stalled.
`default_nettype none

module bmp_out_queue import bmp_pkg::*; (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       push_i,
  input  wire res_group_t group_i,
  input  wire logic       out_stall_i,
  output logic            out_valid_o,
  output res_entry_t      out_entry_o,
  output logic [QCW-1:0]  count_o
);

  res_entry_t      mem_q [QDEPTH];
  logic [QPW-1:0]  rd_ptr_q, wr_ptr_q;
  logic [QCW-1:0]  count_q, count_d;
  logic [QPW-1:0]  wr_ptr_d;
  logic [1:0]      n_push;
  logic            pop;

  assign n_push      = push_i ? group_i.count : 2'd0;
  assign out_valid_o = (count_q != '0);
  assign out_entry_o = mem_q[rd_ptr_q];
  assign pop         = out_valid_o && !out_stall_i;
  assign count_o     = count_q;
  assign wr_ptr_d    = wr_ptr_q + QPW'(n_push);
  assign count_d     = count_q + QCW'(n_push) - QCW'(pop);

  // Queue storage, written at consecutive places after the write pointer.
  always_ff @(posedge clk_i) begin
    for (int k = 0; k < int'(MAX_RESULTS); k++) begin
      if (32'(n_push) > 32'(k)) begin
        mem_q[wr_ptr_q + QPW'(k)] <= group_i.entry[k];
      end
    end
  end

  // Pointers and fill count.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rd_ptr_q <= '0;
      wr_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      count_q  <= count_d;
      if (pop) begin
        rd_ptr_q <= rd_ptr_q + QPW'(1);
      end
    end
  end

endmodule

`default_nettype wire

/* rtl/core/bmp_row_to_packed_pixel_converter.sv */
// Top level of the BMP row to packed pixel converter.
//
//   Channel  | Direction | Handshake              | Payload
//   ---------+-----------+------------------------+---------------------------------
//   config   | in        | cfg_we_i               | cfg_index_i, cfg_data_i
//   input    | in        | in_valid_i, in_stall_o | data_byte_i
//   output   | out       | out_valid_o, out_stall_i | out_byte_o, last_of_run_o, image_end_o
//
// One input byte is taken per cycle while in_stall_o is low; the pixel is formatted in the
// same cycle and its result bytes enter a four-entry queue. The queue hands out one byte per
// cycle while out_stall_i is low, so with an unstalled output a sustained rate of one input
// byte per cycle is kept in every output format. A red byte (the one that completes a pixel)
// stalls only while the queue has fewer than three free places. Reset leaves width 1,
// height 1 and the 12-bit pair format. Any register write restarts the image.
`default_nettype none

module bmp_row_to_packed_pixel_converter import bmp_pkg::*; #(
  parameter int unsigned MAX_WIDTH  = 4096,
  parameter int unsigned MAX_HEIGHT = 4096
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             cfg_we_i,
  input  wire logic [1:0]       cfg_index_i,
  input  wire logic [DIM_W-1:0] cfg_data_i,
  input  wire logic             in_valid_i,
  output logic                  in_stall_o,
  input  wire logic [7:0]       data_byte_i,
  output logic                  out_valid_o,
  input  wire logic             out_stall_i,
  output logic [7:0]            out_byte_o,
  output logic                  last_of_run_o,
  output logic                  image_end_o
);

  `include "bmp_row_to_packed_pixel_converter_defines.svh"

  logic [DIM_W-1:0] width_q, height_q;
  mode_e            mode_q;
  logic [DIM_W-1:0] width_eff, height_eff;
  logic             cfg_hit;
  logic             in_fire;
  logic             will_emit;
  res_group_t       group;
  res_entry_t       head;
  logic [QCW-1:0]   q_count;

  // Register writes; an unknown index is ignored.
  always_comb begin
    unique case (cfg_index_i)
      REG_WIDTH:  cfg_hit = cfg_we_i;
      REG_HEIGHT: cfg_hit = cfg_we_i;
      REG_MODE:   cfg_hit = cfg_we_i;
      default:    cfg_hit = 1'b0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= DIM_W'(1);
      height_q <= DIM_W'(1);
      mode_q   <= MODE_PAIR12;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        REG_WIDTH:  width_q  <= cfg_data_i;
        REG_HEIGHT: height_q <= cfg_data_i;
        REG_MODE:   mode_q   <= mode_e'(cfg_data_i[1:0]);
        default:    ;
      endcase
    end
  end

  // Zero counts as one, and a value above the maximum counts as the maximum.
  always_comb begin
    if (width_q == '0) begin
      width_eff = DIM_W'(1);
    end else if (32'(width_q) > MAX_WIDTH) begin
      width_eff = DIM_W'(MAX_WIDTH);
    end else begin
      width_eff = width_q;
    end
    if (height_q == '0) begin
      height_eff = DIM_W'(1);
    end else if (32'(height_q) > MAX_HEIGHT) begin
      height_eff = DIM_W'(MAX_HEIGHT);
    end else begin
      height_eff = height_q;
    end
  end

  // Hold a completing byte back until the queue can take all its results.
  assign in_stall_o = will_emit && (32'(q_count) > (QDEPTH - MAX_RESULTS));
  assign in_fire    = in_valid_i && !in_stall_o;

  bmp_pixel_asm #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_asm (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .clear_i     (cfg_hit),
    .accept_i    (in_fire),
    .data_byte_i (data_byte_i),
    .width_i     (width_eff),
    .height_i    (height_eff),
    .mode_i      (mode_q),
    .will_emit_o (will_emit),
    .result_o    (group)
  );

  bmp_out_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (in_fire && !cfg_hit),
    .group_i     (group),
    .out_stall_i (out_stall_i),
    .out_valid_o (out_valid_o),
    .out_entry_o (head),
    .count_o     (q_count)
  );

  assign out_byte_o    = head.out_byte;
  assign last_of_run_o = head.last_of_run;
  assign image_end_o   = head.image_end;

  // The queue never holds more than its depth.
  `BMP_ASSERT_ALWAYS(a_queue_bound, clk_i, rst_ni, 32'(q_count) <= QDEPTH, "result queue overflow")

  // The final byte of an image always closes its run.
  `BMP_ASSERT_ALWAYS(a_end_closes_run, clk_i, rst_ni, !out_valid_o || !image_end_o || last_of_run_o, "image end without run end")

  // A completed pixel outside the pair format always leaves a byte to send.
  `BMP_ASSERT_NEXT(a_pixel_gives_byte, clk_i, rst_ni, in_fire && will_emit && !cfg_hit && (mode_q != MODE_PAIR12), out_valid_o, "completed pixel produced no byte")

endmodule

`default_nettype wire
